// ===== sv/dfamc_pkg.sv =====
package dfamc_pkg;

  // default automaton dimensions
  localparam int unsigned NodeCountDefault   = 1024;
  localparam int unsigned ClassCountDefault  = 64;
  localparam int unsigned WeightLimitDefault = 511;

  // fixed field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ByteSpan = 256;
  localparam int unsigned CountW  = 32;

  typedef enum logic [1:0] {
    FUNC_CLASS_MAP = 2'd0,
    FUNC_TRANS     = 2'd1,
    FUNC_WEIGHT    = 2'd2,
    FUNC_TEXT      = 2'd3
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] byte_value;
    logic [5:0] class_index;
    logic [9:0] node_index;
    logic [9:0] next_node;
    logic [8:0] match_weight;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] match_total;
    logic        saturated;
  } rsp_t;

endpackage

// ===== sv/multi_pattern_dfa_match_counter_top.sv =====
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------
// in      | request   | in_valid_i/in_ready_o  | in_req_i   (req_t)
// out     | result    | out_valid_o/out_ready_i| out_rsp_o  (rsp_t)
//
// one request a cycle sustained while the pipeline is not stalled; a text byte marked
// last raises out_valid_o after the class map read at acceptance, then the transition
// read, the weight read and the count update into the output register.
// the node-to-node step is one transition memory read a cycle,
// its read data fed straight back into the next transition address.
// reset clears node, count, pipeline valids and output valid; tables need loading.
// the pipeline stalls only when a result leaves the last stage while the
// output register still holds one that has not been taken.
module multi_pattern_dfa_match_counter_top #(
  parameter int unsigned NODE_COUNT   = dfamc_pkg::NodeCountDefault,
  parameter int unsigned CLASS_COUNT  = dfamc_pkg::ClassCountDefault,
  parameter int unsigned WEIGHT_LIMIT = dfamc_pkg::WeightLimitDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dfamc_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dfamc_pkg::rsp_t  out_rsp_o
);

  import dfamc_pkg::*;

  // table geometry, transition address is {node, class}
  localparam int unsigned NodeW  = $clog2(NODE_COUNT);
  localparam int unsigned ClsW   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int unsigned WtW    = $clog2(WEIGHT_LIMIT + 1);
  localparam int unsigned TransDepth = 1 << (NodeW + ClsW);
  localparam logic [CountW:0] CountSat = {1'b0, {CountW{1'b1}}};

  // pipeline enable: hold everything when a result meets a full output
  logic en;
  logic acc;

  // stage registers
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  req_t s1_q, s2_q;
  logic s3_text_q, s3_last_q;

  // architectural state
  logic [NodeW-1:0]  node_q;
  logic [CountW-1:0] count_q;
  logic              stuck_q;

  // output register
  logic out_valid_q;
  rsp_t out_rsp_q;

  // memory ports
  logic             cmap_we;
  logic [ClsW-1:0]  cmap_wdata, cmap_rdata;
  logic             trans_we;
  logic [NodeW+ClsW-1:0] trans_addr;
  logic [NodeW-1:0] trans_wdata, trans_rdata;
  logic             wt_we;
  logic [NodeW-1:0] wt_addr;
  logic [WtW-1:0]   wt_wdata, wt_rdata;

  logic [NodeW-1:0] cur_node;
  logic             s2_text;
  logic             emit;
  logic [CountW:0]  sum;
  logic [CountW-1:0] count_new;
  logic             stuck_new;

  assign emit       = s3_valid_q && s3_text_q && s3_last_q;
  assign en         = !(emit && out_valid_q && !out_ready_i);
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;

  // ---- stage 0: class map, written or read with the accepted request
  assign cmap_we    = acc && (in_req_i.func == FUNC_CLASS_MAP) &&
                      (32'(in_req_i.class_index) < CLASS_COUNT);
  assign cmap_wdata = ClsW'(in_req_i.class_index);

  dfamc_ram #(
    .WIDTH (ClsW),
    .DEPTH (ByteSpan)
  ) u_class_map (
    .clk_i   (clk_i),
    .en_i    (en),
    .we_i    (cmap_we),
    .addr_i  (in_req_i.byte_value),
    .wdata_i (cmap_wdata),
    .rdata_o (cmap_rdata)
  );

  // ---- stage 1: transition step
  assign s2_text = s2_valid_q && (s2_q.func == FUNC_TEXT);

  // node forwarded from the transition read of the byte one stage ahead
  always_comb begin
    if (s2_text) begin
      cur_node = s2_q.last_byte ? '0 : trans_rdata;
    end else begin
      cur_node = node_q;
    end
  end

  assign trans_we    = s1_valid_q && (s1_q.func == FUNC_TRANS) &&
                       (32'(s1_q.class_index) < CLASS_COUNT) &&
                       (32'(s1_q.node_index) < NODE_COUNT) &&
                       (32'(s1_q.next_node) < NODE_COUNT);
  assign trans_addr  = trans_we ? {NodeW'(s1_q.node_index), ClsW'(s1_q.class_index)}
                                : {cur_node, cmap_rdata};
  assign trans_wdata = NodeW'(s1_q.next_node);

  dfamc_ram #(
    .WIDTH (NodeW),
    .DEPTH (TransDepth)
  ) u_transition (
    .clk_i   (clk_i),
    .en_i    (en),
    .we_i    (trans_we),
    .addr_i  (trans_addr),
    .wdata_i (trans_wdata),
    .rdata_o (trans_rdata)
  );

  // ---- stage 2: weight of the node just reached
  assign wt_we    = s2_valid_q && (s2_q.func == FUNC_WEIGHT) &&
                    (32'(s2_q.node_index) < NODE_COUNT);
  assign wt_addr  = wt_we ? NodeW'(s2_q.node_index) : trans_rdata;
  assign wt_wdata = (32'(s2_q.match_weight) > WEIGHT_LIMIT) ? WtW'(WEIGHT_LIMIT)
                                                            : WtW'(s2_q.match_weight);

  dfamc_ram #(
    .WIDTH (WtW),
    .DEPTH (NODE_COUNT)
  ) u_node_weight (
    .clk_i   (clk_i),
    .en_i    (en),
    .we_i    (wt_we),
    .addr_i  (wt_addr),
    .wdata_i (wt_wdata),
    .rdata_o (wt_rdata)
  );

  // ---- stage 3: saturating count
  assign sum = {1'b0, count_q} + (CountW + 1)'(wt_rdata);

  always_comb begin
    if (sum >= CountSat) begin
      count_new = {CountW{1'b1}};
      stuck_new = 1'b1;
    end else begin
      count_new = sum[CountW-1:0];
      stuck_new = stuck_q;
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      node_q     <= '0;
      count_q    <= '0;
      stuck_q    <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      // node moves as the transition read data comes back
      if (s2_text) begin
        node_q <= s2_q.last_byte ? '0 : trans_rdata;
      end
      // count moves as the weight comes back, cleared at the end of a text
      if (s3_valid_q && s3_text_q) begin
        if (s3_last_q) begin
          count_q <= '0;
          stuck_q <= 1'b0;
        end else begin
          count_q <= count_new;
          stuck_q <= stuck_new;
        end
      end
    end
  end

  // stage payloads, no reset
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= in_req_i;
      s2_q      <= s1_q;
      s3_text_q <= s2_text;
      s3_last_q <= s2_q.last_byte;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit && en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && en) begin
      out_rsp_q.match_total <= count_new;
      out_rsp_q.saturated   <= stuck_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== sv/dfamc_ram.sv =====
module dfamc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, read data held while disabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
